// ===== rtl/core/sxd_pkg.sv =====
// shared types, constants and wrap tables for the sprite xor framebuffer
// no dependencies; used by the top level and sxd_addr under rtl/core
package sxd_pkg;

    // frame geometry and sprite limits
    localparam int FRAME_WIDTH     = 64;
    localparam int FRAME_HEIGHT    = 32;
    localparam int MAX_SPRITE_ROWS = 15;

    // sprite byte layout: bit TOP_BIT is the leftmost pixel
    localparam int SPRITE_BITS = 8;
    localparam int TOP_BIT     = 7;

    // fixed port widths
    localparam int COORD_W   = 8;
    localparam int OUT_PIX_W = 64;

    // derived widths
    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int RC_W  = (MAX_SPRITE_ROWS > 1) ? $clog2(MAX_SPRITE_ROWS + 1) : 1;

    typedef enum logic [1:0] {
        MODE_DRAW  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_mode              mode;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [7:0]         sprite_row;
        logic               last_row;
    } t_in_item;

    typedef struct packed {
        logic                 collision;
        logic                 sprite_done;
        logic [OUT_PIX_W-1:0] row_pixels;
        logic                 was_dirty;
    } t_out_item;

    // frame row to touch and the columns the sprite byte flips
    typedef struct packed {
        logic [ROW_W-1:0]       row;
        logic [FRAME_WIDTH-1:0] mask;
    } t_row_sel;

    // v mod m for every 8-bit v, built by counting at elaboration
    typedef logic [255:0][7:0] t_mod_tab;

    function automatic t_mod_tab build_mod_tab(input int m);
        t_mod_tab tab;
        int r;
        r = 0;
        for (int v = 0; v < 256; v++) begin
            tab[v] = 8'(r);
            r = (r == m - 1) ? 0 : r + 1;
        end
        return tab;
    endfunction

    localparam t_mod_tab X_TAB = build_mod_tab(FRAME_WIDTH);
    localparam t_mod_tab Y_TAB = build_mod_tab(FRAME_HEIGHT);

endpackage

// ===== rtl/core/sprite_xor_draw_framebuffer_unit.sv =====
// top level of the sprite xor framebuffer: handshake, control and frame memory
// depends on sxd_pkg, sxd_ram and sxd_addr
//
// usage
//   input channel: i_in_valid / o_in_ready carry one t_in_item beat per command.
//   mode draw xors one sprite byte into frame row (origin_y + sprite row) mod
//   height, mode clear blanks the frame, mode read returns one frame row and
//   the dirty flag. output channel: o_out_valid / i_out_ready carry exactly
//   one t_out_item beat per accepted input beat, in order.
// timing
//   the accept cycle issues the frame row read (registered ram read); the
//   execute state then modifies, writes back and loads the result register
//   once the output register is free. a new command waits until the previous one
//   leaves execute, set by the read-then-write pass over the single frame memory
//   port pair. a result is visible on o_out_valid the cycle after the execute cycle.
// stalls
//   a new command is taken while the previous result still waits in the output
//   register; it then holds in execute until that result is taken, with no
//   state changed, so nothing is lost or repeated.
// reset
//   per-row valid flags clear in the reset cycle, so the frame reads as blank
//   at once with no sweep; dirty flag comes up set, sprite row count and
//   collision flag come up zero. the block takes a command right after reset.
module sprite_xor_draw_framebuffer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sxd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sxd_pkg::t_out_item o_out_item
);

    // control state
    sxd_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            r_dirty, n_dirty;
    logic [sxd_pkg::RC_W-1:0] r_rc, n_rc;
    logic            r_coll, n_coll;
    logic [sxd_pkg::FRAME_HEIGHT-1:0] r_row_valid, n_row_valid;

    // payload held across the execute cycle
    sxd_pkg::t_in_item  r_item, n_item;
    logic [sxd_pkg::ROW_W-1:0]       r_row, n_row;
    logic [sxd_pkg::FRAME_WIDTH-1:0] r_mask, n_mask;
    sxd_pkg::t_out_item r_out, n_out;

    // address unit and memory
    sxd_pkg::t_row_sel w_sel;
    logic [sxd_pkg::RC_W-1:0] w_offset;
    logic                            w_ram_re;
    logic                            w_ram_we;
    logic [sxd_pkg::FRAME_WIDTH-1:0] w_ram_rdata;
    logic [sxd_pkg::FRAME_WIDTH-1:0] w_old;
    logic [sxd_pkg::FRAME_WIDTH-1:0] w_new;
    logic                            w_hit;
    logic                            w_room;
    logic                            w_commit;

    // read mode ignores the sprite row count
    assign w_offset = (i_in_item.mode == sxd_pkg::MODE_DRAW) ? r_rc : '0;

    sxd_addr u_addr (
        .i_origin_x   (i_in_item.origin_x),
        .i_origin_y   (i_in_item.origin_y),
        .i_sprite_row (i_in_item.sprite_row),
        .i_row_offset (w_offset),
        .o_sel        (w_sel)
    );

    sxd_ram #(
        .WIDTH (sxd_pkg::FRAME_WIDTH),
        .DEPTH (sxd_pkg::FRAME_HEIGHT)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_row),
        .i_wdata (w_new),
        .i_re    (w_ram_re),
        .i_raddr (w_sel.row),
        .o_rdata (w_ram_rdata)
    );

    // a row never written since reset or the last clear reads as blank
    assign w_old    = r_row_valid[r_row] ? w_ram_rdata : '0;
    assign w_new    = w_old ^ r_mask;
    assign w_hit    = |(w_old & r_mask);
    assign w_room   = (r_rc < sxd_pkg::RC_W'(sxd_pkg::MAX_SPRITE_ROWS));
    // the output register is free or drains this cycle
    assign w_commit = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == sxd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_dirty     = r_dirty;
        n_rc        = r_rc;
        n_coll      = r_coll;
        n_row_valid = r_row_valid;
        n_item      = r_item;
        n_row       = r_row;
        n_mask      = r_mask;
        n_out       = r_out;
        w_ram_re    = 1'b0;
        w_ram_we    = 1'b0;

        case (r_state)
            sxd_pkg::ST_IDLE: begin
                // take the beat and start the frame row read
                if (i_in_valid) begin
                    n_item   = i_in_item;
                    n_row    = w_sel.row;
                    n_mask   = w_sel.mask;
                    w_ram_re = 1'b1;
                    n_state  = sxd_pkg::ST_EXEC;
                end
            end
            sxd_pkg::ST_EXEC: begin
                // read data holds while the result register is blocked
                if (w_commit) begin
                    n_state     = sxd_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (r_item.mode)
                        sxd_pkg::MODE_DRAW: begin
                            // rows past the sprite limit leave the frame alone
                            if (w_room) begin
                                w_ram_we           = 1'b1;
                                n_row_valid[r_row] = 1'b1;
                                n_coll             = r_coll | w_hit;
                                n_rc               = r_rc + 1'b1;
                            end
                            n_dirty = 1'b1;
                            if (r_item.last_row) begin
                                n_out.collision   = n_coll;
                                n_out.sprite_done = 1'b1;
                                n_rc              = '0;
                                n_coll            = 1'b0;
                            end
                        end
                        sxd_pkg::MODE_CLEAR: begin
                            // dropping the valid flags blanks every row at once
                            n_row_valid = '0;
                            n_dirty     = 1'b1;
                            n_rc        = '0;
                            n_coll      = 1'b0;
                        end
                        sxd_pkg::MODE_READ: begin
                            n_out.row_pixels = sxd_pkg::OUT_PIX_W'(w_old);
                            n_out.was_dirty  = r_dirty;
                            n_dirty          = 1'b0;
                        end
                        default: begin
                            // unused mode: all-zero result, no state change
                        end
                    endcase
                end
            end
            default: begin
                n_state = sxd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sxd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_dirty     <= 1'b1;
            r_rc        <= '0;
            r_coll      <= 1'b0;
            r_row_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dirty     <= n_dirty;
            r_rc        <= n_rc;
            r_coll      <= n_coll;
            r_row_valid <= n_row_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_row  <= n_row;
        r_mask <= n_mask;
        r_out  <= n_out;
    end

    // every finished command leaves a result beat waiting
    a_commit_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sxd_pkg::ST_EXEC && w_commit) |=> o_out_valid)
        else $error("executed command produced no result beat");

    // a clear leaves no row marked as written
    a_clear_blanks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sxd_pkg::ST_EXEC && w_commit && r_item.mode == sxd_pkg::MODE_CLEAR)
        |=> (r_row_valid == '0 && r_rc == '0 && !r_coll))
        else $error("clear left frame or sprite state behind");

    // a sprite completion never carries read data
    a_done_no_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.sprite_done)
        |-> (o_out_item.row_pixels == '0 && !o_out_item.was_dirty))
        else $error("sprite done beat carries read fields");

    // the sprite row count saturates at the limit
    a_rc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rc <= sxd_pkg::RC_W'(sxd_pkg::MAX_SPRITE_ROWS)))
        else $error("sprite row count past limit");

endmodule

// ===== rtl/core/sxd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module sxd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sxd_addr.sv =====
// row address and column flip mask for one sprite byte, with wrap on both axes
// depends on sxd_pkg (wrap tables, widths, t_row_sel)
module sxd_addr (
    input  logic [sxd_pkg::COORD_W-1:0] i_origin_x,
    input  logic [sxd_pkg::COORD_W-1:0] i_origin_y,
    input  logic [7:0]                  i_sprite_row,
    input  logic [sxd_pkg::RC_W-1:0]    i_row_offset,
    output sxd_pkg::t_row_sel           o_sel
);

    logic [sxd_pkg::COL_W-1:0]   w_xm;
    logic [sxd_pkg::ROW_W-1:0]   w_ym;
    logic [sxd_pkg::ROW_W-1:0]   w_rm;
    logic [sxd_pkg::ROW_W:0]     w_ysum;
    logic [sxd_pkg::COL_W:0]     w_csum;
    logic [sxd_pkg::COL_W-1:0]   w_col;
    logic [sxd_pkg::FRAME_WIDTH-1:0] w_mask;

    assign w_xm = sxd_pkg::X_TAB[i_origin_x][sxd_pkg::COL_W-1:0];
    assign w_ym = sxd_pkg::Y_TAB[i_origin_y][sxd_pkg::ROW_W-1:0];
    assign w_rm = sxd_pkg::Y_TAB[8'(i_row_offset)][sxd_pkg::ROW_W-1:0];

    // both terms are below the height, so one subtract wraps the sum
    assign w_ysum = {1'b0, w_ym} + {1'b0, w_rm};

    assign o_sel.row = (w_ysum >= (sxd_pkg::ROW_W + 1)'(sxd_pkg::FRAME_HEIGHT))
                     ? w_ysum[sxd_pkg::ROW_W-1:0]
                       - sxd_pkg::ROW_W'(sxd_pkg::FRAME_HEIGHT)
                     : w_ysum[sxd_pkg::ROW_W-1:0];

    // pixel k of the byte (k from the left) lands at column xm + k, wrapped
    always_comb begin
        w_mask = '0;
        w_csum = '0;
        w_col  = '0;
        for (int k = 0; k < sxd_pkg::SPRITE_BITS; k++) begin
            w_csum = {1'b0, w_xm} + (sxd_pkg::COL_W + 1)'(k);
            if (w_csum >= (sxd_pkg::COL_W + 1)'(sxd_pkg::FRAME_WIDTH)) begin
                w_csum = w_csum - (sxd_pkg::COL_W + 1)'(sxd_pkg::FRAME_WIDTH);
            end
            w_col = w_csum[sxd_pkg::COL_W-1:0];
            if (i_sprite_row[sxd_pkg::TOP_BIT - k]) begin
                w_mask[w_col] = 1'b1;
            end
        end
    end

    assign o_sel.mask = w_mask;

endmodule
